/* hw/rtl/rpt_pkg.sv */
// shared types, widths and command codes for the rigid point transform unit
package rpt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int ELEM_W    = 32;  // matrix element and coordinate width
   localparam int OPA_W     = 33;  // first multiplier operand, holds p - t exactly
   localparam int MUL_W     = 65;  // full product width
   localparam int NUM_ELEMS = 12;
   localparam int NUM_LANES = 3;
   localparam int IDX_W     = 4;
   localparam int CMD_W     = 3;

   // request tdata layout
   localparam int REQ_IDX_LSB = 0;
   localparam int REQ_VAL_LSB = REQ_IDX_LSB + IDX_W;
   localparam int REQ_X_LSB   = REQ_VAL_LSB + ELEM_W;
   localparam int REQ_Y_LSB   = REQ_X_LSB + ELEM_W;
   localparam int REQ_Z_LSB   = REQ_Y_LSB + ELEM_W;
   localparam int REQ_USED_W  = REQ_Z_LSB + ELEM_W;
   localparam int REQ_DATA_W  = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_DATA_W  = NUM_LANES * ELEM_W;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [OPA_W-1:0]  opa_type;

   localparam elem_type ELEM_MAX = elem_type'({1'b0, {(ELEM_W-1){1'b1}}});
   localparam elem_type ELEM_MIN = elem_type'({1'b1, {(ELEM_W-1){1'b0}}});

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD           = 3'd0,
      CMD_ROT_L2P        = 3'd1,
      CMD_ROT_TRANS_L2P  = 3'd2,
      CMD_ROT_P2L        = 3'd3,
      CMD_TRANS_ROT_P2L  = 3'd4,
      CMD_INVERT         = 3'd5
   } cmd_type;

   // control carried alongside the lane datapath
   typedef struct packed {
      logic valid;
      logic invert;
      logic last;
   } stage_ctl_type;

   // per-stage load enables for the lanes
   typedef struct packed {
      logic a;
      logic b;
      logic c;
   } lane_en_type;

endpackage

/* hw/rtl/rpt_lane.sv */
// one row lane: operand register, three multipliers with shift, row sum
module rpt_lane #(
   parameter int FRAC_BITS = rpt_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  rpt_pkg::lane_en_type                   en,
   input  rpt_pkg::opa_type                       opa [3],
   input  rpt_pkg::elem_type                      opb [3],
   input  rpt_pkg::elem_type                      addend,
   output logic signed [rpt_pkg::MUL_W-FRAC_BITS+1:0] sum
);
   import rpt_pkg::*;

   localparam int PROD_W = MUL_W - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 2;

   opa_type                  opa_ff [3];
   opa_type                  opa_in [3];
   elem_type                 opb_ff [3];
   elem_type                 opb_in [3];
   elem_type                 add_a_ff, add_a_in;
   elem_type                 add_b_ff, add_b_in;
   logic signed [MUL_W-1:0]  full [3];
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         opa_in[j]  = en.a ? opa[j] : opa_ff[j];
         opb_in[j]  = en.a ? opb[j] : opb_ff[j];
         // floor of the product over 2^frac
         full[j]    = MUL_W'(opa_ff[j]) * MUL_W'(opb_ff[j]);
         prod_in[j] = en.b ? PROD_W'(full[j] >>> FRAC_BITS) : prod_ff[j];
      end
      add_a_in = en.a ? addend : add_a_ff;
      add_b_in = en.b ? add_a_ff : add_b_ff;
      sum_in   = en.c ? (SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(prod_ff[2])
                         + SUM_W'(add_b_ff))
                      : sum_ff;
   end

   always_ff @(posedge clock) begin
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      add_a_ff <= add_a_in;
      prod_ff  <= prod_in;
      add_b_ff <= add_b_in;
      sum_ff   <= sum_in;
   end

   assign sum = sum_ff;

endmodule

/* hw/rtl/rpt_merge.sv */
// merge stage: saturates the three row sums, ors overflow, output register
module rpt_merge #(
   parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rpt_pkg::FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  rpt_pkg::stage_ctl_type                     ctl_c,
   input  logic signed [rpt_pkg::MUL_W-FRAC_BITS+1:0] sum [3],
   output logic                                       c_ready,
   output rpt_pkg::elem_type                          inv_t [3],
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [rpt_pkg::RSP_DATA_W-1:0]             rsp_tdata,
   output logic [0:0]                                 rsp_tuser,
   output logic                                       rsp_tlast
);
   import rpt_pkg::*;

   localparam int SUM_W = MUL_W - FRAC_BITS + 2;
   localparam int SAT_W = (COORD_WIDTH > ELEM_W) ? ELEM_W : COORD_WIDTH;
   localparam elem_type SAT_MAX = elem_type'({{(ELEM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}});
   localparam elem_type SAT_MIN = ~SAT_MAX;

   logic                  out_ready;
   logic                  fits [3];
   logic                  fits_inv [3];
   elem_type              coord [3];
   logic signed [SUM_W:0] neg [3];
   logic                  any_ovf;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;

   always_comb begin
      any_ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
         fits[i]  = (&sum[i][SUM_W-1:SAT_W-1]) || !(|sum[i][SUM_W-1:SAT_W-1]);
         coord[i] = fits[i] ? ELEM_W'($signed(sum[i][SAT_W-1:0]))
                            : (sum[i][SUM_W-1] ? SAT_MIN : SAT_MAX);
         any_ovf  = any_ovf | !fits[i];
         // new translation of an inverse, saturated to the element width
         neg[i]      = -((SUM_W+1)'(sum[i]));
         fits_inv[i] = (&neg[i][SUM_W:ELEM_W-1]) || !(|neg[i][SUM_W:ELEM_W-1]);
         inv_t[i]    = fits_inv[i] ? neg[i][ELEM_W-1:0]
                                   : (neg[i][SUM_W] ? ELEM_MIN : ELEM_MAX);
      end
   end

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign c_ready   = !ctl_c.valid || ctl_c.invert || out_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      data_in      = data_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      if (out_ready) begin
         rsp_valid_in = ctl_c.valid && !ctl_c.invert;
         data_in      = {coord[2], coord[1], coord[0]};
         ovf_in       = any_ovf;
         last_in      = ctl_c.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = ovf_ff;
   assign rsp_tlast    = last_ff;

endmodule

/* hw/rtl/rigid_point_transform_unit.sv */
// top level of the rigid point transform unit: matrix store, operand select, lanes, merge
//
// Holds a 3x4 rigid transform (rotation R, translation t) in signed fixed point and
// transforms one point per clock as R*p, R*p + t, R^T*p or R^T*(p - t), picked by the
// command in req_tuser. Three row lanes, each with three multipliers, work side by side
// and a merge stage saturates the rows and raises overflow. A point transaction is taken
// every cycle while the pipeline does not stall and no invert is pending. The accepting
// edge loads the operand registers, and the product, sum and output registers follow
// in that order, the output register driving rsp_tvalid. The pipeline stalls only when
// rsp_tready holds it full. A load writes one element in the accepting cycle and gives
// no result. An invert transposes R at once and runs -R^T t through the lanes.
// req_tready stays low until its new translation is written back from the sum stage.
// Commands 6 and 7 are dropped.
module rigid_point_transform_unit #(
   parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rpt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] elem_index, [35:4] elem_value, [67:36] point_x, [99:68] point_y,
   // [131:100] point_z, [135:132] zero
   input  logic [rpt_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] cmd
   input  logic [rpt_pkg::CMD_W-1:0]         req_tuser,
   input  logic                              req_tlast,   // last_point
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z
   output logic [rpt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] overflow
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast    // last_out
);
   import rpt_pkg::*;

   localparam int SUM_W = MUL_W - FRAC_BITS + 2;
   localparam elem_type UNIT = elem_type'(ELEM_W'(64'd1 << FRAC_BITS));

   // request fields
   cmd_type          cmd;
   logic [IDX_W-1:0] idx;
   elem_type         val;
   elem_type         pt [3];

   logic             accept;
   logic             is_point;
   logic             is_inv;

   // matrix store, element at row*4 + column
   elem_type         mat_ff [NUM_ELEMS];
   elem_type         mat_in [NUM_ELEMS];

   // lane operands
   opa_type          opa [NUM_LANES][3];
   elem_type         opb [NUM_LANES][3];
   elem_type         addend [NUM_LANES];
   logic signed [SUM_W-1:0] sum [3];
   elem_type         inv_t [3];

   // pipeline control
   stage_ctl_type    ctl_a_ff, ctl_a_in;
   stage_ctl_type    ctl_b_ff, ctl_b_in;
   stage_ctl_type    ctl_c_ff, ctl_c_in;
   logic             a_ready, b_ready, c_ready;
   lane_en_type      lane_en;
   logic             inv_wb;
   logic             inv_busy_ff, inv_busy_in;

   assign cmd   = cmd_type'(req_tuser);
   assign idx   = req_tdata[REQ_IDX_LSB +: IDX_W];
   assign val   = req_tdata[REQ_VAL_LSB +: ELEM_W];
   assign pt[0] = req_tdata[REQ_X_LSB +: ELEM_W];
   assign pt[1] = req_tdata[REQ_Y_LSB +: ELEM_W];
   assign pt[2] = req_tdata[REQ_Z_LSB +: ELEM_W];

   always_comb begin
      is_point = 1'b0;
      is_inv   = 1'b0;
      case (cmd)
         CMD_ROT_L2P, CMD_ROT_TRANS_L2P, CMD_ROT_P2L, CMD_TRANS_ROT_P2L: is_point = 1'b1;
         CMD_INVERT: is_inv = 1'b1;
         default: ;
      endcase
   end

   // ready chain, bubbles collapse toward the output register
   assign b_ready    = !ctl_b_ff.valid || c_ready;
   assign a_ready    = !ctl_a_ff.valid || b_ready;
   assign req_tready = a_ready && !inv_busy_ff;
   assign accept     = req_tvalid && req_tready;

   assign lane_en.a = a_ready;
   assign lane_en.b = b_ready;
   assign lane_en.c = c_ready;

   // invert transaction reaching the sum stage writes back its translation
   assign inv_wb = ctl_c_ff.valid && ctl_c_ff.invert;

   // operand select per lane (row i) and term j
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         for (int j = 0; j < 3; j++) begin
            case (cmd)
               CMD_ROT_L2P, CMD_ROT_TRANS_L2P: begin
                  opa[i][j] = OPA_W'(mat_ff[IDX_W'(4*i+j)]);
                  opb[i][j] = pt[j];
               end
               CMD_ROT_P2L: begin
                  opa[i][j] = OPA_W'(pt[j]);
                  opb[i][j] = mat_ff[IDX_W'(4*j+i)];
               end
               CMD_TRANS_ROT_P2L: begin
                  // p - t kept exact at 33 bits
                  opa[i][j] = OPA_W'(pt[j]) - OPA_W'(mat_ff[IDX_W'(4*j+3)]);
                  opb[i][j] = mat_ff[IDX_W'(4*j+i)];
               end
               CMD_INVERT: begin
                  // R^T t from the old matrix, negated in the merge stage
                  opa[i][j] = OPA_W'(mat_ff[IDX_W'(4*j+3)]);
                  opb[i][j] = mat_ff[IDX_W'(4*j+i)];
               end
               default: begin
                  opa[i][j] = '0;
                  opb[i][j] = '0;
               end
            endcase
         end
         addend[i] = (cmd == CMD_ROT_TRANS_L2P) ? mat_ff[IDX_W'(4*i+3)] : '0;
      end
   end

   // matrix updates: load, transpose on invert, translation write-back
   always_comb begin
      mat_in = mat_ff;
      if (accept && cmd == CMD_LOAD && idx < IDX_W'(NUM_ELEMS)) begin
         mat_in[idx] = val;
      end
      if (accept && is_inv) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               mat_in[IDX_W'(4*r+c)] = mat_ff[IDX_W'(4*c+r)];
            end
         end
      end
      if (inv_wb) begin
         for (int r = 0; r < 3; r++) begin
            mat_in[IDX_W'(4*r+3)] = inv_t[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ELEMS; k++) begin
            mat_ff[k] <= (k == 0 || k == 5 || k == 10) ? UNIT : '0;
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   // control pipeline alongside the lanes
   always_comb begin
      ctl_a_in = ctl_a_ff;
      if (a_ready) begin
         ctl_a_in.valid  = accept && (is_point || is_inv);
         ctl_a_in.invert = is_inv;
         ctl_a_in.last   = req_tlast;
      end
      ctl_b_in    = b_ready ? ctl_a_ff : ctl_b_ff;
      ctl_c_in    = c_ready ? ctl_b_ff : ctl_c_ff;
      inv_busy_in = inv_busy_ff;
      if (accept && is_inv) begin
         inv_busy_in = 1'b1;
      end else if (inv_wb) begin
         inv_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff    <= '0;
         ctl_b_ff    <= '0;
         ctl_c_ff    <= '0;
         inv_busy_ff <= 1'b0;
      end else begin
         ctl_a_ff    <= ctl_a_in;
         ctl_b_ff    <= ctl_b_in;
         ctl_c_ff    <= ctl_c_in;
         inv_busy_ff <= inv_busy_in;
      end
   end

   // one lane per output row
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      rpt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .en     (lane_en),
         .opa    (opa[g]),
         .opb    (opb[g]),
         .addend (addend[g]),
         .sum    (sum[g])
      );
   end

   rpt_merge #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctl_c      (ctl_c_ff),
      .sum        (sum),
      .c_ready    (c_ready),
      .inv_t      (inv_t),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/rpt_checker.sv */
// port-level checks for the rigid point transform unit, bound to the top level
module rpt_checker #(
   parameter int COORD_WIDTH = rpt_pkg::COORD_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [rpt_pkg::CMD_W-1:0]      req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rpt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                     rsp_tuser
);
   import rpt_pkg::*;

   localparam int SAT_W = (COORD_WIDTH > ELEM_W) ? ELEM_W : COORD_WIDTH;
   localparam elem_type SAT_MAX = elem_type'({{(ELEM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}});
   localparam elem_type SAT_MIN = ~SAT_MAX;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // overflow implies some coordinate sits at a saturation bound
   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[31:0] == SAT_MAX || rsp_tdata[31:0] == SAT_MIN ||
         rsp_tdata[63:32] == SAT_MAX || rsp_tdata[63:32] == SAT_MIN ||
         rsp_tdata[95:64] == SAT_MAX || rsp_tdata[95:64] == SAT_MIN)
      else $error("overflow flagged without a saturated coordinate");

   // an invert holds off the next transaction until its translation is written
   a_inv_block: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_INVERT |=> !req_tready)
      else $error("transaction accepted during invert");

endmodule

bind rigid_point_transform_unit rpt_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_rpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/rigid_point_transform_unit_tb.sv */
// self-checking testbench for the rigid point transform unit with its own fixed-point predictor
module rigid_point_transform_unit_tb;
   import rpt_pkg::*;

   // run length and pacing
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 435;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int WIDE_W       = MUL_W + 1;

   // commands the block drops without a result
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   // handy Q16.16 constants
   localparam elem_type FIX_ONE  = 32'sh0001_0000;
   localparam elem_type FIX_TWO  = 32'sh0002_0000;
   localparam elem_type FIX_NEG3 = -32'sh0003_0000;

   // saturation bounds, sign extended to the accumulator width
   localparam logic signed [63:0] SAT_HI = 64'(ELEM_MAX);
   localparam logic signed [63:0] SAT_LO = 64'(ELEM_MIN);

   typedef struct {
      elem_type x;
      elem_type y;
      elem_type z;
      logic     last;
      logic     ovf;
   } point_result_t;

   // one directed transaction; the expected point is typed in only where it is obvious
   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      elem_type         value;
      elem_type         x;
      elem_type         y;
      elem_type         z;
      logic             last;
      logic             typed;
      elem_type         ex;
      elem_type         ey;
      elem_type         ez;
      logic             eovf;
   } stim_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  rsp_tlast;

   // predictor copy of the twelve matrix elements, row*4 + column
   elem_type      xform_state [NUM_ELEMS];
   // transformed points still owed by the block, oldest first
   point_result_t expected_points [$];

   // pacing knobs, written by the stimulus process only
   int            send_idle_pct;
   int            rsp_stall_pct;
   int            hold_request_len;

   // directed rows with a hand-written expectation
   logic          typed_pending;
   point_result_t typed_result;

   int            error_count;
   int            cycle_count;
   int            points_sent;
   int            points_saturated;
   int            loads_sent;
   int            inverts_sent;
   int            spares_sent;
   int            results_checked;

   // directed table: reset identity first, then extremes, dropped commands,
   // out-of-range loads, saturation, wide p - t, and invert with overflow
   stim_row_t directed_rows [23] = '{
      // identity after reset, every mode passes the point through
      '{CMD_ROT_L2P, 4'd0, 32'sd0, FIX_ONE, FIX_TWO, FIX_NEG3, 1'b0,
        1'b1, FIX_ONE, FIX_TWO, FIX_NEG3, 1'b0},
      '{CMD_ROT_TRANS_L2P, 4'd0, 32'sd0, ELEM_MAX, ELEM_MIN, 32'sd0, 1'b1,
        1'b1, ELEM_MAX, ELEM_MIN, 32'sd0, 1'b0},
      '{CMD_ROT_P2L, 4'd0, 32'sd0, ELEM_MIN, ELEM_MAX, 32'sd1, 1'b0,
        1'b1, ELEM_MIN, ELEM_MAX, 32'sd1, 1'b0},
      '{CMD_TRANS_ROT_P2L, 4'd0, 32'sd0, -32'sd1, 32'sd0, ELEM_MAX, 1'b1,
        1'b1, -32'sd1, 32'sd0, ELEM_MAX, 1'b0},
      // unused commands, must leave nothing behind
      '{CMD_SPARE_6, 4'd0, 32'sd0, FIX_ONE, FIX_ONE, FIX_ONE, 1'b1,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_SPARE_7, 4'd15, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MAX, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      // loads past element eleven change nothing
      '{CMD_LOAD, 4'd12, ELEM_MAX, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_LOAD, 4'd15, ELEM_MIN, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_ROT_L2P, 4'd0, 32'sd0, 32'sd3, -32'sd5, 32'sd7, 1'b1,
        1'b1, 32'sd3, -32'sd5, 32'sd7, 1'b0},
      // large translation column
      '{CMD_LOAD, 4'd3, 32'sh7FFF_0000, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_LOAD, 4'd7, ELEM_MIN, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_LOAD, 4'd11, 32'sh0001_8000, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      // adding t saturates high and low
      '{CMD_ROT_TRANS_L2P, 4'd0, 32'sd0, 32'sh7FFF_0000, ELEM_MIN, FIX_ONE, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      // p - t needs the 33rd bit
      '{CMD_TRANS_ROT_P2L, 4'd0, 32'sd0, ELEM_MIN, ELEM_MAX, 32'sd0, 1'b1,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      // extreme rotation elements
      '{CMD_LOAD, 4'd1, ELEM_MIN, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_LOAD, 4'd0, ELEM_MAX, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_LOAD, 4'd10, 32'shFFFF_0000, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_ROT_L2P, 4'd0, 32'sd0, ELEM_MAX, ELEM_MAX, ELEM_MIN, 1'b1,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_ROT_P2L, 4'd0, 32'sd0, ELEM_MIN, 32'sd1, ELEM_MAX, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      // invert with a translation that overflows, then use it and invert back
      '{CMD_INVERT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_ROT_TRANS_L2P, 4'd0, 32'sd0, FIX_ONE, FIX_ONE, FIX_ONE, 1'b0,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_INVERT, 4'd9, ELEM_MAX, ELEM_MAX, ELEM_MIN, ELEM_MAX, 1'b1,
        1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
      '{CMD_TRANS_ROT_P2L, 4'd0, 32'sd0, 32'sh1234_5678, 32'shEDCB_A987,
        32'sh0F0F_0F0F, 1'b1, 1'b0, 32'sd0, 32'sd0, 32'sd0, 1'b0}
   };

   rigid_point_transform_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // exact product floored by FRAC_BITS, a holds up to 33 bits
   function automatic logic signed [63:0] scaled_product(input opa_type a, input elem_type b);
      logic signed [WIDE_W-1:0] wa;
      logic signed [WIDE_W-1:0] wb;
      logic signed [WIDE_W-1:0] full;
      wa   = WIDE_W'(a);
      wb   = WIDE_W'(b);
      full = wa * wb;
      full = full >>> FRAC_BITS_DEF;
      return full[63:0];
   endfunction

   // clamp a row sum to a 32-bit coordinate
   function automatic elem_type clamp_word(input logic signed [63:0] v, output logic hit);
      hit = 1'b0;
      if (v > SAT_HI) begin
         hit = 1'b1;
         return ELEM_MAX;
      end
      if (v < SAT_LO) begin
         hit = 1'b1;
         return ELEM_MIN;
      end
      return v[ELEM_W-1:0];
   endfunction

   // predictor: applies one accepted transaction to the matrix copy and
   // works out the transformed point where the command yields one
   task automatic apply_transform_command(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] idx,
                                          input elem_type value,
                                          input elem_type px, py, pz,
                                          input logic last,
                                          output logic produced,
                                          output point_result_t res);
      elem_type           prior [NUM_ELEMS];
      elem_type           pin [NUM_LANES];
      opa_type            pt [NUM_LANES];
      elem_type           lane_out [NUM_LANES];
      logic signed [63:0] acc;
      logic               hit;
      int                 i;
      int                 k;
      produced = 1'b0;
      res      = '{x: '0, y: '0, z: '0, last: 1'b0, ovf: 1'b0};
      pin[0]   = px;
      pin[1]   = py;
      pin[2]   = pz;
      case (cmd)
         CMD_LOAD: begin
            if (idx < NUM_ELEMS) xform_state[idx] = value;
         end
         CMD_INVERT: begin
            // new rotation is the transpose, new t is -(R^T t) from the old values
            prior = xform_state;
            for (i = 0; i < NUM_LANES; i++)
               for (k = 0; k < NUM_LANES; k++)
                  xform_state[i*4+k] = prior[k*4+i];
            for (i = 0; i < NUM_LANES; i++) begin
               acc = '0;
               for (k = 0; k < NUM_LANES; k++)
                  acc += scaled_product(opa_type'(xform_state[i*4+k]), prior[k*4+3]);
               xform_state[i*4+3] = clamp_word(-acc, hit);
            end
         end
         CMD_ROT_L2P, CMD_ROT_TRANS_L2P, CMD_ROT_P2L, CMD_TRANS_ROT_P2L: begin
            for (k = 0; k < NUM_LANES; k++) begin
               pt[k] = opa_type'(pin[k]);
               if (cmd == CMD_TRANS_ROT_P2L) pt[k] = pt[k] - opa_type'(xform_state[k*4+3]);
            end
            for (i = 0; i < NUM_LANES; i++) begin
               acc = '0;
               for (k = 0; k < NUM_LANES; k++) begin
                  if (cmd == CMD_ROT_L2P || cmd == CMD_ROT_TRANS_L2P)
                     acc += scaled_product(opa_type'(xform_state[i*4+k]), pin[k]);
                  else
                     acc += scaled_product(pt[k], xform_state[k*4+i]);
               end
               if (cmd == CMD_ROT_TRANS_L2P) acc += 64'(xform_state[i*4+3]);
               lane_out[i] = clamp_word(acc, hit);
               res.ovf     = res.ovf | hit;
            end
            res.x    = lane_out[0];
            res.y    = lane_out[1];
            res.z    = lane_out[2];
            res.last = last;
            produced = 1'b1;
         end
         default: begin
         end
      endcase
   endtask

   function automatic elem_type pick_element();
      case ($urandom_range(15))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2, 3:    return elem_type'($urandom);
         // mostly rotation-sized values around +-1.5
         default: return elem_type'($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      endcase
   endfunction

   function automatic elem_type pick_coord();
      case ($urandom_range(9))
         0:       return ELEM_MAX;
         1:       return ELEM_MIN;
         2, 3, 4: return elem_type'($urandom);
         // coordinates within +-256.0
         default: return elem_type'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
      endcase
   endfunction

   // present one transaction at the falling edge and hold it until taken;
   // returns at the falling edge after the accepting rising edge
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input elem_type value, input elem_type px, py, pz,
                            input logic last);
      logic [REQ_DATA_W-1:0] bus;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      bus = '0;
      bus[REQ_IDX_LSB +: IDX_W]  = idx;
      bus[REQ_VAL_LSB +: ELEM_W] = value;
      bus[REQ_X_LSB +: ELEM_W]   = px;
      bus[REQ_Y_LSB +: ELEM_W]   = py;
      bus[REQ_Z_LSB +: ELEM_W]   = pz;
      req_tdata  = bus;
      req_tuser  = cmd;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // random mix of loads, inverts, dropped commands and point transforms
   task automatic run_random_phase(input int target, input int idle_pct, input int stall_pct);
      int               sent;
      int               pick;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent          = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         idx  = IDX_W'($urandom_range(15));
         if (pick < 14) begin
            cmd = CMD_LOAD;
            // mostly real elements, sometimes the unused indexes
            if ($urandom_range(7) != 0) idx = IDX_W'($urandom_range(NUM_ELEMS - 1));
         end else if (pick < 18) begin
            cmd = CMD_INVERT;
         end else if (pick < 20) begin
            cmd = ($urandom_range(1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6;
         end else begin
            case ($urandom_range(3))
               0:       cmd = CMD_ROT_L2P;
               1:       cmd = CMD_ROT_TRANS_L2P;
               2:       cmd = CMD_ROT_P2L;
               default: cmd = CMD_TRANS_ROT_P2L;
            endcase
         end
         send_item(cmd, idx, pick_element(), pick_coord(), pick_coord(), pick_coord(),
                   1'($urandom_range(3) == 0));
         // dropped commands do not count toward the phase
         if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7) sent++;
      end
   endtask

   // free-running clock, period 2
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls at the falling edge, plus one long hold-off on request
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request_len != 0 && !hold_done) begin
            hold_left = hold_request_len;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog: generous bound on the whole run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, expected_points.size());
      $display("status: fail");
      $finish;
   end

   // rising-edge monitor: check the response transaction first, then predict
   // from the request transaction taken at the same edge
   always @(posedge clock) begin : edge_watch
      point_result_t    want;
      point_result_t    got;
      point_result_t    predicted;
      logic             produced;
      logic [CMD_W-1:0] cmd;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.x    = rsp_tdata[0 +: ELEM_W];
            got.y    = rsp_tdata[ELEM_W +: ELEM_W];
            got.z    = rsp_tdata[2*ELEM_W +: ELEM_W];
            got.last = rsp_tlast;
            got.ovf  = rsp_tuser[0];
            if (expected_points.size() == 0) begin
               $error("result transaction with nothing expected: x %0d y %0d z %0d",
                      got.x, got.y, got.z);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               results_checked++;
               if (got.x !== want.x) begin
                  $error("out_x mismatch: expected %0d, actual %0d", want.x, got.x);
                  error_count++;
               end
               if (got.y !== want.y) begin
                  $error("out_y mismatch: expected %0d, actual %0d", want.y, got.y);
                  error_count++;
               end
               if (got.z !== want.z) begin
                  $error("out_z mismatch: expected %0d, actual %0d", want.z, got.z);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last_out mismatch: expected %0b, actual %0b", want.last, got.last);
                  error_count++;
               end
               if (got.ovf !== want.ovf) begin
                  $error("overflow mismatch: expected %0b, actual %0b", want.ovf, got.ovf);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            cmd = req_tuser;
            apply_transform_command(cmd, req_tdata[REQ_IDX_LSB +: IDX_W],
                                    req_tdata[REQ_VAL_LSB +: ELEM_W],
                                    req_tdata[REQ_X_LSB +: ELEM_W],
                                    req_tdata[REQ_Y_LSB +: ELEM_W],
                                    req_tdata[REQ_Z_LSB +: ELEM_W],
                                    req_tlast, produced, predicted);
            case (cmd)
               CMD_LOAD:   loads_sent++;
               CMD_INVERT: inverts_sent++;
               default: begin
                  if (!produced) spares_sent++;
               end
            endcase
            if (produced) begin
               points_sent++;
               if (predicted.ovf) points_saturated++;
               // hand-written expectation wins on the directed rows that carry one
               expected_points.push_back(typed_pending ? typed_result : predicted);
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = CMD_LOAD;
      req_tlast        = 1'b0;
      reset            = 1'b1;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_request_len = 0;
      typed_pending    = 1'b0;
      typed_result     = '{x: '0, y: '0, z: '0, last: 1'b0, ovf: 1'b0};
      error_count      = 0;
      points_sent      = 0;
      points_saturated = 0;
      loads_sent       = 0;
      inverts_sent     = 0;
      spares_sent      = 0;
      results_checked  = 0;

      // matrix after reset: identity rotation, zero translation
      foreach (xform_state[n]) xform_state[n] = '0;
      xform_state[0]  = FIX_ONE;
      xform_state[5]  = FIX_ONE;
      xform_state[10] = FIX_ONE;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[n]) begin
         typed_pending = directed_rows[n].typed;
         typed_result  = '{x: directed_rows[n].ex, y: directed_rows[n].ey,
                           z: directed_rows[n].ez, last: directed_rows[n].last,
                           ovf: directed_rows[n].eovf};
         send_item(directed_rows[n].cmd, directed_rows[n].idx, directed_rows[n].value,
                   directed_rows[n].x, directed_rows[n].y, directed_rows[n].z,
                   directed_rows[n].last);
         typed_pending = 1'b0;
      end

      // back to back with a long output hold-off at the start, so the pipe
      // fills and req_tready drops while transactions keep coming
      hold_request_len = LONG_HOLD;
      run_random_phase(PHASE_ITEMS, 0, 0);
      // sparse sender
      run_random_phase(PHASE_ITEMS, 87, 0);
      // slow receiver
      run_random_phase(PHASE_ITEMS, 0, 87);
      // both sides idling now and then
      run_random_phase(PHASE_ITEMS, 31, 31);
      req_tvalid = 1'b0;

      // drain, then a few more cycles to catch anything extra
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d point transforms (%0d saturating), %0d element loads, %0d inverts",
               points_sent, points_saturated, loads_sent, inverts_sent);
      $display("and %0d dropped commands; %0d results checked over four pacing phases",
               spares_sent, results_checked);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
